FILE: rtl/ttgp_pkg.sv
package ttgp_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned SHIFT_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned CELLS    = TIME_W;
  localparam int unsigned PROD_W   = 62;
  localparam int unsigned NS_W     = 30;

  localparam logic [NS_W-1:0]    NS_PER_SECOND = NS_W'(1000000000);
  localparam logic [SHIFT_W-1:0] MAX_SHIFT     = SHIFT_W'(64);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = SHIFT_W'(32);

  localparam logic [INDEX_W-1:0] REG_NUMERATOR   = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_DENOMINATOR = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] REG_SHIFT       = INDEX_W'(2);

  localparam logic [STATUS_W-1:0] ST_OK          = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_KEY_AFTER   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_INDEX_WIDE  = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_OFFSET_WIDE = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = STATUS_W'(4);

  typedef struct packed {
    logic [TIME_W-1:0] keyframe_time;
    logic [TIME_W-1:0] frame_time;
  } request_t;

  typedef struct packed {
    logic [TIME_W-1:0]   granule_pos;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   key_rem;
    logic [TIME_W-1:0]   key_num;
    logic [TIME_W-1:0]   frame_rem;
    logic [TIME_W-1:0]   frame_num;
  } cell_t;

endpackage

FILE: rtl/ttgp_period.sv
module ttgp_period
  import ttgp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic [INDEX_W-1:0]  index,
  input  logic [RATE_W-1:0]   data,
  output logic                busy,
  output logic [TIME_W-1:0]   period
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t              state;
  logic [RATE_W-1:0]   numerator;
  logic [RATE_W-1:0]   denominator;
  logic [PROD_W-1:0]   quot;
  logic [RATE_W-1:0]   rem;
  logic [5:0]          count;
  logic [RATE_W:0]     trial;
  logic                ge;

  assign trial = {rem, quot[PROD_W-1]};
  assign ge    = trial >= {1'b0, numerator};
  assign busy  = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      numerator   <= RATE_W'(1);
      denominator <= RATE_W'(1);
      period      <= TIME_W'(NS_PER_SECOND);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (wr && index == REG_NUMERATOR) begin
            numerator <= data;
            state     <= S_MUL;
          end else if (wr && index == REG_DENOMINATOR) begin
            denominator <= data;
            state       <= S_MUL;
          end
        end
        S_MUL: begin
          quot  <= PROD_W'({{(PROD_W-NS_W){1'b0}}, NS_PER_SECOND} *
                           {{(PROD_W-RATE_W){1'b0}}, denominator});
          rem   <= '0;
          count <= 6'(PROD_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= ge ? RATE_W'(trial - {1'b0, numerator}) : trial[RATE_W-1:0];
          quot  <= {quot[PROD_W-2:0], ge};
          count <= count - 6'd1;
          if (count == '0) begin
            period <= (numerator == '0) ? '0
                      : {{(TIME_W-PROD_W){1'b0}}, quot[PROD_W-2:0], ge};
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_period_fits: assert property (@(posedge clk) disable iff (rst)
    period[TIME_W-1:PROD_W] == '0) else $error("period exceeds 62 bits");
  a_zero_num: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && numerator == '0 |-> period == '0)
    else $error("zero numerator must give zero period");
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(wr && (index == REG_NUMERATOR || index == REG_DENOMINATOR)))
    else $error("period update without rate write");
`endif

endmodule

FILE: rtl/ttgp_cell.sv
module ttgp_cell
  import ttgp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [TIME_W-1:0] divisor,
  input  cell_t             din,
  output cell_t             dout
);

  logic [TIME_W-1:0] key_trial;
  logic [TIME_W-1:0] frame_trial;
  logic              key_ge;
  logic              frame_ge;

  assign key_trial   = {din.key_rem[TIME_W-2:0], din.key_num[TIME_W-1]};
  assign frame_trial = {din.frame_rem[TIME_W-2:0], din.frame_num[TIME_W-1]};
  assign key_ge      = key_trial >= divisor;
  assign frame_ge    = frame_trial >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.status    <= din.status;
    dout.key_rem   <= key_ge ? key_trial - divisor : key_trial;
    dout.key_num   <= {din.key_num[TIME_W-2:0], key_ge};
    dout.frame_rem <= frame_ge ? frame_trial - divisor : frame_trial;
    dout.frame_num <= {din.frame_num[TIME_W-2:0], frame_ge};
  end

endmodule

FILE: rtl/ttgp_final.sv
module ttgp_final
  import ttgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [SHIFT_W-1:0] shift,
  input  cell_t              din,
  output logic               done,
  output result_t            result
);

  logic                valid_a;
  logic [STATUS_W-1:0] status_a;
  logic [TIME_W-1:0]   idx_a;
  logic [TIME_W-1:0]   off_a;
  logic                idx_over;
  logic                off_over;
  logic [STATUS_W-1:0] status_next;

  assign idx_over = (din.key_num >> (MAX_SHIFT - shift)) != '0;
  assign off_over = (shift == MAX_SHIFT) ? 1'b0 : ((off_a >> shift) != '0);

  always_comb begin
    status_next = status_a;
    if (status_a == ST_OK && off_over) begin
      status_next = ST_OFFSET_WIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_a <= din.valid;
      done    <= valid_a;
    end
    status_a <= (din.status == ST_OK && idx_over) ? ST_INDEX_WIDE : din.status;
    idx_a    <= din.key_num;
    off_a    <= din.frame_num - din.key_num;
    result.status <= status_next;
    if (status_next != ST_OK) begin
      result.granule_pos <= '0;
    end else if (shift == MAX_SHIFT) begin
      result.granule_pos <= off_a;
    end else begin
      result.granule_pos <= (idx_a << shift) + off_a;
    end
  end

endmodule

FILE: rtl/timestamp_to_granule_position_core.sv
// Requests pass from start to done through a pipeline; one accepted every cycle while busy is low.
// The pipeline is the 64 restoring-division cells plus two finishing stages.
// A write to a rate register holds busy high while the period is recomputed
// by a bit-serial divider; the result side cannot stall.
// Reset (synchronous, rst high) empties the pipeline and restores rate 1/1, shift 32.
module timestamp_to_granule_position_core
  import ttgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  request_t           request,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]  cfg_data
);

  logic                cfg_wr;
  logic [SHIFT_W-1:0]  shift;
  logic [TIME_W-1:0]   period;
  logic                period_busy;
  logic [TIME_W-1:0]   key_time;
  cell_t               chain [CELLS+1];

  assign busy      = period_busy;
  assign cfg_ready = !period_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_time  = (&request.keyframe_time) ? '0 : request.keyframe_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= SHIFT_RESET;
    end else if (cfg_wr && cfg_index == REG_SHIFT) begin
      shift <= (cfg_data[SHIFT_W-1:0] > MAX_SHIFT) ? MAX_SHIFT : cfg_data[SHIFT_W-1:0];
    end
  end

  always_comb begin
    chain[0].valid     = start && !busy;
    chain[0].key_rem   = '0;
    chain[0].key_num   = key_time;
    chain[0].frame_rem = '0;
    chain[0].frame_num = request.frame_time;
    if (key_time > request.frame_time) begin
      chain[0].status = ST_KEY_AFTER;
    end else if (period == '0) begin
      chain[0].status = ST_ZERO_PERIOD;
    end else begin
      chain[0].status = ST_OK;
    end
  end

  ttgp_period u_period (
    .clk    (clk),
    .rst    (rst),
    .wr     (cfg_wr),
    .index  (cfg_index),
    .data   (cfg_data),
    .busy   (period_busy),
    .period (period)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ttgp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (period),
      .din     (chain[i]),
      .dout    (chain[i+1])
    );
  end

  ttgp_final u_final (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .din    (chain[CELLS]),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !chain[0].valid) else $error("transaction accepted while busy");
  a_zero_period_status: assert property (@(posedge clk) disable iff (rst)
    chain[0].valid && period == '0 && chain[0].status != ST_KEY_AFTER
    |-> chain[0].status == ST_ZERO_PERIOD) else $error("zero period not flagged");
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    shift <= MAX_SHIFT) else $error("shift out of range");
`endif

endmodule

FILE: tb/tb.sv
module tb;
  import ttgp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 70;

  class granule_scoreboard;
    logic [RATE_W-1:0]   numerator;
    logic [RATE_W-1:0]   denominator;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [TIME_W-1:0]   period;
    result_t             pending_results[$];
    int unsigned         mismatches;

    function void reset_state();
      numerator   = RATE_W'(1);
      denominator = RATE_W'(1);
      shift_amt   = SHIFT_RESET;
      period      = 64'd1000000000;
      pending_results.delete();
      mismatches  = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] idx, logic [RATE_W-1:0] data);
      case (idx)
        REG_NUMERATOR:   numerator = data;
        REG_DENOMINATOR: denominator = data;
        REG_SHIFT:       shift_amt = data[SHIFT_W-1:0];
        default: ;
      endcase
      if (idx == REG_NUMERATOR || idx == REG_DENOMINATOR) begin
        if (numerator == 0) period = '0;
        else period = (64'd1000000000 * 64'(denominator)) / 64'(numerator);
      end
    endfunction

    function void note_request(request_t req);
      logic [TIME_W-1:0]  key_t;
      logic [TIME_W-1:0]  key_idx;
      logic [TIME_W-1:0]  offset;
      logic [TIME_W-1:0]  max_index;
      logic [TIME_W-1:0]  max_offset;
      logic [SHIFT_W-1:0] sh;
      result_t            res;
      res   = '0;
      key_t = req.keyframe_time;
      sh    = (shift_amt > MAX_SHIFT) ? MAX_SHIFT : shift_amt;
      if (&key_t) key_t = '0;
      if (key_t > req.frame_time) begin
        res.status = ST_KEY_AFTER;
      end else if (period == 0) begin
        res.status = ST_ZERO_PERIOD;
      end else begin
        key_idx = key_t / period;
        if (sh == 0) max_index = '1;
        else if (sh == MAX_SHIFT) max_index = '0;
        else max_index = {TIME_W{1'b1}} >> sh;
        if (sh == MAX_SHIFT) max_offset = '1;
        else max_offset = (64'd1 << sh) - 64'd1;
        if (key_idx > max_index) begin
          res.status = ST_INDEX_WIDE;
        end else begin
          offset = req.frame_time / period - key_idx;
          if (offset > max_offset) res.status = ST_OFFSET_WIDE;
          else if (sh == MAX_SHIFT) res.granule_pos = offset;
          else res.granule_pos = (key_idx << sh) + offset;
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result pos=%h status=%0d", got.granule_pos, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.granule_pos !== want.granule_pos || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pos=%h status=%0d, got pos=%h status=%0d",
                   want.granule_pos, want.status, got.granule_pos, got.status);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  request_t           request = '0;
  logic               done;
  result_t            result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = REG_NUMERATOR;
  logic [RATE_W-1:0]  cfg_data = '0;

  granule_scoreboard  board;
  int unsigned        cycle_count = 0;
  int unsigned        idle_pct = 0;

  timestamp_to_granule_position_core uut (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  task automatic send_request(logic [TIME_W-1:0] key_t, logic [TIME_W-1:0] frame_t);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    request.keyframe_time = key_t;
    request.frame_time = frame_t;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(request);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [TIME_W-1:0] key_t;
    logic [TIME_W-1:0] frame_t;
    int unsigned       mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      key_t = '1;
      frame_t = {$urandom, $urandom};
    end else if (mode == 1) begin
      key_t = {$urandom, $urandom};
      frame_t = {$urandom, $urandom};
    end else begin
      key_t = rand_time();
      frame_t = key_t + rand_time();
      if (frame_t < key_t) frame_t = '1;
    end
    send_request(key_t, frame_t);
  endtask

  task automatic drain();
    start = 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [RATE_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_rate(logic [RATE_W-1:0] num, logic [RATE_W-1:0] den,
                          logic [SHIFT_W-1:0] sh);
    drain();
    write_reg(REG_NUMERATOR, num);
    write_reg(REG_DENOMINATOR, den);
    write_reg(REG_SHIFT, ($urandom & 32'hFFFF_FF80) | 32'(sh));
  endtask

  initial begin
    static logic [RATE_W-1:0]  nums[10] = '{1, 32'hFFFF_FFFF, 30000, 1, 0, 25, 48000, 7, 1, 3};
    static logic [RATE_W-1:0]  dens[10] = '{1, 1, 1001, 32'hFFFF_FFFF, 5, 0, 1, 3, 1, 32'hFFFF};
    static logic [SHIFT_W-1:0] shifts[10] = '{0, 1, 16, 64, 32, 127, 40, 65, 63, 8};
    board = new();
    board.reset_state();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_request('0, '0);
    send_request('1, '1);
    send_request('1, 64'd5_000_000_000);
    send_request(64'd3_000_000_000, 64'd2_000_000_000);
    send_request(64'd2_000_000_000, 64'd7_500_000_000);
    send_request('1 - 64'd1, '1);
    send_request(64'd1 << 62, (64'd1 << 62) + 64'd999_999_999);
    send_request(64'd0, 64'h0000_00FF_FFFF_FFFF);
    send_request(64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000);
    send_request(64'd999_999_999, 64'd1_000_000_000);

    set_rate(1, 1, 0);
    send_request(64'd1_000_000_000, 64'd1_000_000_000);
    send_request(64'd1_000_000_000, 64'd2_000_000_000);
    send_request('1 - 64'd1, '1 - 64'd1);
    set_rate(1, 1, 64);
    send_request(64'd0, '1);
    send_request(64'd1_000_000_000, 64'd1_000_000_000);
    set_rate(0, 1, 32);
    send_request(64'd10, 64'd20);
    send_request(64'd30, 64'd20);
    set_rate(1, 0, 127);
    send_request(64'd0, 64'd1);
    send_request('1, '0);

    for (int p = 0; p < 10; p++) begin
      set_rate(nums[p], dens[p], shifts[p]);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 38;
        default: idle_pct = 0;
      endcase
      repeat (160) send_random();
    end

    drain();
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
